// ===== rtl/core/aee_pkg.sv =====
// Package for the ASCII expression evaluator.
// Holds the datapath width, character codes, operator and status codes and the
// request/response structs shared by the sequencer and the arithmetic unit.
`default_nettype none

package aee_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [DATA_WIDTH-1:0] RADIX = DATA_WIDTH'(10);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } alu_op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_LEAD = 2'd1,
    ST_BAD     = 2'd2,
    ST_DIV0    = 2'd3
  } status_e;

  typedef struct packed {
    logic                  start;
    alu_op_e               op;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                  done;
    logic [DATA_WIDTH-1:0] result;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/aee_alu.sv =====
// Shared arithmetic unit of the ASCII expression evaluator.
// Add and subtract are registered straight from the request; shift-add multiply and
// restoring signed divide, one bit per cycle. Depends on aee_pkg.
`default_nettype none

module aee_alu
  import aee_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire alu_req_t req_i,
  output alu_rsp_t      rsp_o
);

  typedef enum logic [1:0] {
    AS_IDLE = 2'b01,
    AS_BUSY = 2'b10
  } alu_state_e;

  alu_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic done_q, done_d;
  alu_op_e op_q, op_d;
  logic neg_q, neg_d;
  logic [DATA_WIDTH-1:0] x_q, x_d, y_q, y_d, z_q, z_d, res_q, res_d;

  logic [DATA_WIDTH-1:0] prod_sum;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   rem_sub;
  logic                  q_bit;
  logic [DATA_WIDTH-1:0] rem_next;
  logic [DATA_WIDTH-1:0] quo_next;
  logic [DATA_WIDTH-1:0] abs_a;
  logic [DATA_WIDTH-1:0] abs_b;

  always_comb begin
    prod_sum = z_q + (y_q[0] ? x_q : '0);
    rem_sh   = {z_q, y_q[DATA_WIDTH-1]};
    rem_sub  = rem_sh - {1'b0, x_q};
    q_bit    = ~rem_sub[DATA_WIDTH];
    rem_next = q_bit ? rem_sub[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
    quo_next = {y_q[DATA_WIDTH-2:0], q_bit};
    abs_a    = req_i.a[DATA_WIDTH-1] ? (~req_i.a + 1'b1) : req_i.a;
    abs_b    = req_i.b[DATA_WIDTH-1] ? (~req_i.b + 1'b1) : req_i.b;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    op_d    = op_q;
    neg_d   = neg_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    res_d   = res_q;
    case (state_q)
      AS_IDLE: begin
        if (req_i.start) begin
          cnt_d = '0;
          op_d  = req_i.op;
          z_d   = '0;
          case (req_i.op)
            OP_ADD: begin
              res_d  = req_i.a + req_i.b;
              done_d = 1'b1;
            end
            OP_SUB: begin
              res_d  = req_i.a - req_i.b;
              done_d = 1'b1;
            end
            OP_MUL: begin
              x_d     = req_i.a;
              y_d     = req_i.b;
              state_d = AS_BUSY;
            end
            default: begin
              x_d     = abs_b;
              y_d     = abs_a;
              neg_d   = req_i.a[DATA_WIDTH-1] ^ req_i.b[DATA_WIDTH-1];
              state_d = AS_BUSY;
            end
          endcase
        end
      end
      AS_BUSY: begin
        cnt_d = cnt_q + 1'b1;
        if (op_q == OP_MUL) begin
          z_d = prod_sum;
          x_d = x_q << 1;
          y_d = y_q >> 1;
        end else begin
          z_d = rem_next;
          y_d = quo_next;
        end
        if (cnt_q == CNT_W'(DATA_WIDTH - 1)) begin
          done_d  = 1'b1;
          state_d = AS_IDLE;
          if (op_q == OP_MUL) begin
            res_d = prod_sum;
          end else begin
            res_d = neg_q ? (~quo_next + 1'b1) : quo_next;
          end
        end
      end
      default: begin
        state_d = AS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AS_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    neg_q <= neg_d;
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    res_q <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/ascii_expression_evaluator.sv =====
// Top level of the ASCII expression evaluator: character sequencer, line state
// and output register around the shared arithmetic unit.
// Depends on aee_pkg and aee_alu.
//
// Usage: characters enter on the input channel (in_valid_i, in_ready_o, ch_i),
// one beat per character. A line is decimal numbers joined by + - * / and is
// evaluated strictly left to right; a zero byte ends it. Each terminator yields
// one beat on the output channel (out_valid_o, out_ready_i, value_o, status_o).
// The first digit of a line and an operator after a first number are taken
// without the shared unit. Every later digit runs a multiply by ten and an add
// on the shared unit. A completed operand is applied on the same unit, and a
// terminator then passes through the emit state into the output register.
// The input is not ready while the shared unit works or a result is queued.
// If the receiver stalls, the result is held in the output register and the
// block keeps taking characters until the next result has to be queued.
// Reset clears the line state and drops any queued result.
`default_nettype none

module ascii_expression_evaluator
  import aee_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  ch_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [15:0] value_o,
  output logic [1:0]       status_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL10 = 5'b00010,
    S_ADDD  = 5'b00100,
    S_APPLY = 5'b01000,
    S_EMIT  = 5'b10000
  } seq_state_e;

  typedef enum logic [4:0] {
    PH_FIRST       = 5'b00001,
    PH_IN_FIRST    = 5'b00010,
    PH_EXPECT_OPND = 5'b00100,
    PH_IN_OPND     = 5'b01000,
    PH_SKIP        = 5'b10000
  } phase_e;

  seq_state_e state_q, state_d;
  phase_e phase_q, phase_d;
  alu_op_e pend_q, pend_d;
  status_e err_q, err_d;
  status_e emit_st_q, emit_st_d;
  logic [DATA_WIDTH-1:0] acc_q, acc_d, opnd_q, opnd_d;
  logic [7:0] ch_q, ch_d;
  logic [3:0] dig_q, dig_d;
  logic tgt_q, tgt_d;
  logic [15:0] emit_val_q, emit_val_d;
  logic out_valid_q, out_valid_d;
  logic [15:0] value_q, value_d;
  status_e status_q, status_d;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic in_digit;
  logic do_after;
  logic do_emit;
  logic [DATA_WIDTH-1:0] emit_v;
  status_e emit_s;
  logic [7:0] an_ch;
  logic [DATA_WIDTH-1:0] an_acc;

  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
  endfunction

  function automatic alu_op_e op_code(input logic [7:0] c);
    alu_op_e r;
    r = OP_DIV;
    if (c == CH_PLUS) r = OP_ADD;
    else if (c == CH_MINUS) r = OP_SUB;
    else if (c == CH_STAR) r = OP_MUL;
    return r;
  endfunction

  aee_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_digit   = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign an_ch      = (state_q == S_APPLY) ? ch_q : ch_i;
  assign an_acc     = (state_q == S_APPLY) ? alu_rsp.result : acc_q;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    pend_d      = pend_q;
    err_d       = err_q;
    acc_d       = acc_q;
    opnd_d      = opnd_q;
    ch_d        = ch_q;
    dig_d       = dig_q;
    tgt_d       = tgt_q;
    emit_val_d  = emit_val_q;
    emit_st_d   = emit_st_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    value_d     = value_q;
    status_d    = status_q;
    alu_req     = '0;
    do_after    = 1'b0;
    do_emit     = 1'b0;
    emit_v      = '0;
    emit_s      = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ch_d  = ch_i;
          dig_d = 4'(ch_i - CH_ZERO);
          case (phase_q)
            PH_IN_FIRST: begin
              if (in_digit) begin
                alu_req.start = 1'b1;
                alu_req.op    = OP_MUL;
                alu_req.a     = acc_q;
                alu_req.b     = RADIX;
                tgt_d         = 1'b0;
                state_d       = S_MUL10;
              end else begin
                do_after = 1'b1;
              end
            end
            PH_EXPECT_OPND: begin
              if (in_digit) begin
                opnd_d  = DATA_WIDTH'(4'(ch_i - CH_ZERO));
                phase_d = PH_IN_OPND;
              end else if (ch_i == CH_NUL) begin
                do_emit = 1'b1;
                emit_v  = acc_q;
                emit_s  = ST_BAD;
              end else begin
                err_d   = ST_BAD;
                phase_d = PH_SKIP;
              end
            end
            PH_IN_OPND: begin
              if (in_digit) begin
                alu_req.start = 1'b1;
                alu_req.op    = OP_MUL;
                alu_req.a     = opnd_q;
                alu_req.b     = RADIX;
                tgt_d         = 1'b1;
                state_d       = S_MUL10;
              end else if ((pend_q == OP_DIV) && (opnd_q == '0)) begin
                if (ch_i == CH_NUL) begin
                  do_emit = 1'b1;
                  emit_v  = acc_q;
                  emit_s  = ST_DIV0;
                end else begin
                  err_d   = ST_DIV0;
                  phase_d = PH_SKIP;
                end
              end else begin
                alu_req.start = 1'b1;
                alu_req.op    = pend_q;
                alu_req.a     = acc_q;
                alu_req.b     = opnd_q;
                state_d       = S_APPLY;
              end
            end
            PH_SKIP: begin
              if (ch_i == CH_NUL) begin
                do_emit = 1'b1;
                emit_v  = (err_q == ST_NO_LEAD) ? '0 : acc_q;
                emit_s  = err_q;
              end
            end
            default: begin
              if (in_digit) begin
                acc_d   = DATA_WIDTH'(4'(ch_i - CH_ZERO));
                phase_d = PH_IN_FIRST;
              end else if (ch_i == CH_NUL) begin
                do_emit = 1'b1;
                emit_v  = '0;
                emit_s  = ST_NO_LEAD;
              end else begin
                err_d   = ST_NO_LEAD;
                phase_d = PH_SKIP;
              end
            end
          endcase
        end
      end
      S_MUL10: begin
        if (alu_rsp.done) begin
          alu_req.start = 1'b1;
          alu_req.op    = OP_ADD;
          alu_req.a     = alu_rsp.result;
          alu_req.b     = DATA_WIDTH'(dig_q);
          state_d       = S_ADDD;
        end
      end
      S_ADDD: begin
        if (alu_rsp.done) begin
          if (tgt_q) begin
            opnd_d = alu_rsp.result;
          end else begin
            acc_d = alu_rsp.result;
          end
          state_d = S_IDLE;
        end
      end
      S_APPLY: begin
        if (alu_rsp.done) begin
          acc_d    = alu_rsp.result;
          state_d  = S_IDLE;
          do_after = 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          value_d     = emit_val_q;
          status_d    = emit_st_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (do_after) begin
      if (an_ch == CH_NUL) begin
        do_emit = 1'b1;
        emit_v  = an_acc;
        emit_s  = ST_OK;
      end else if (is_op(an_ch)) begin
        pend_d  = op_code(an_ch);
        phase_d = PH_EXPECT_OPND;
      end else begin
        err_d   = ST_BAD;
        phase_d = PH_SKIP;
      end
    end

    if (do_emit) begin
      emit_val_d = 16'(emit_v);
      emit_st_d  = emit_s;
      acc_d      = '0;
      opnd_d     = '0;
      pend_d     = OP_ADD;
      phase_d    = PH_FIRST;
      err_d      = ST_OK;
      state_d    = S_EMIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_FIRST;
      pend_q      <= OP_ADD;
      err_q       <= ST_OK;
      acc_q       <= '0;
      opnd_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      pend_q      <= pend_d;
      err_q       <= err_d;
      acc_q       <= acc_d;
      opnd_q      <= opnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    dig_q      <= dig_d;
    tgt_q      <= tgt_d;
    emit_val_q <= emit_val_d;
    emit_st_q  <= emit_st_d;
    value_q    <= value_d;
    status_q   <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

// ===== rtl/core/aee_checker.sv =====
// Port-level checker for the ASCII expression evaluator and its bind.
// Depends on aee_pkg and the ports of ascii_expression_evaluator.
`default_nettype none

module aee_checker
  import aee_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [7:0]  ch_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] value_o,
  input wire logic [1:0]  status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(value_o) && $stable(status_o))
    else $error("output payload changed while stalled");

  a_no_lead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_NO_LEAD) |-> (value_o == 16'd0))
    else $error("missing leading number must report zero");

  a_no_rise_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared while the sequencer was taking a character");

  a_busy_after_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (ch_i == CH_NUL) |=> !in_ready_o)
    else $error("terminator did not stop the input channel");

endmodule

bind ascii_expression_evaluator aee_checker u_aee_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .ch_i        (ch_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .value_o     (value_o),
  .status_o    (status_o)
);

`default_nettype wire

// ===== tb/ascii_expression_evaluator_tb.sv =====
// Self-checking testbench for ascii_expression_evaluator: a directed table of lines, then
// random lines, mostly well formed, with random receiver stalls and sender gaps, no gaps on
// steady lines. Depends on aee_pkg and the RTL; its line evaluator predicts untyped results.
`default_nettype none

module ascii_expression_evaluator_tb;
  import aee_pkg::*;

  localparam int RANDOM_CHARS   = 850;
  localparam int MAX_IDLE       = 18;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  typedef enum logic [2:0] {
    WAIT_LEAD,
    IN_LEAD,
    WAIT_OPND,
    IN_OPND,
    DISCARD
  } line_phase_e;

  typedef struct packed {
    logic signed [15:0] value;
    status_e            status;
  } line_result_t;

  typedef struct {
    string              txt;
    bit                 typed;
    logic signed [15:0] value;
    status_e            status;
  } line_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [7:0]        ch_i        = 8'h00;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic signed [15:0] value_o;
  logic [1:0]        status_o;

  // Lines are sent with a terminator appended; typed rows carry the result of that terminator.
  line_row_t line_table [8] = '{
    '{"",            1'b1, 16'sd0,    ST_NO_LEAD},
    '{"\377",        1'b1, 16'sd0,    ST_NO_LEAD},
    '{"7+",          1'b1, 16'sd7,    ST_BAD},
    '{"9/0",         1'b1, 16'sd9,    ST_DIV0},
    '{"5x",          1'b1, 16'sd5,    ST_BAD},
    '{"3-*",         1'b1, 16'sd3,    ST_BAD},
    '{"8-9*7/2",     1'b0, 16'sd0,    ST_OK},
    '{"32768/65535", 1'b1, 16'sh8000, ST_OK}
  };

  logic [15:0]  acc_q;
  logic [15:0]  opnd_q;
  alu_op_e      op_q;
  line_phase_e  phase_q;
  status_e      err_q;

  line_result_t result_q [$];
  logic [7:0]   line_q [$];
  bit           steady_line;
  int           chars_sent;
  int           lines_sent;
  int           results_seen;
  int           status_seen [4];
  int           mismatches;
  int           idle_cycles;

  ascii_expression_evaluator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .ch_i        (ch_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .status_o    (status_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic clear_line();
    acc_q   = '0;
    opnd_q  = '0;
    op_q    = OP_ADD;
    phase_q = WAIT_LEAD;
    err_q   = ST_OK;
  endtask

  function automatic bit decode_op(input logic [7:0] c, output alu_op_e op);
    op = OP_ADD;
    case (c)
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      default:  return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic close_number(input logic [7:0] c, output bit done, output line_result_t r);
    alu_op_e op;
    done = 1'b0;
    r    = '0;
    if (c == CH_NUL) begin
      done = 1'b1;
      r    = '{acc_q, ST_OK};
    end else if (decode_op(c, op)) begin
      op_q    = op;
      phase_q = WAIT_OPND;
    end else begin
      err_q   = ST_BAD;
      phase_q = DISCARD;
    end
  endtask

  task automatic eval_char(input logic [7:0] c, output bit done, output line_result_t r);
    logic [15:0] digit;
    bit          is_digit;
    int          quot;
    done     = 1'b0;
    r        = '0;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    digit    = 16'(c) - 16'(CH_ZERO);
    case (phase_q)
      IN_LEAD: begin
        if (is_digit) acc_q = acc_q * RADIX + digit;
        else close_number(c, done, r);
      end
      WAIT_OPND: begin
        if (is_digit) begin
          opnd_q  = digit;
          phase_q = IN_OPND;
        end else if (c == CH_NUL) begin
          done = 1'b1;
          r    = '{acc_q, ST_BAD};
        end else begin
          err_q   = ST_BAD;
          phase_q = DISCARD;
        end
      end
      IN_OPND: begin
        if (is_digit) begin
          opnd_q = opnd_q * RADIX + digit;
        end else if (op_q == OP_DIV && opnd_q == '0) begin
          if (c == CH_NUL) begin
            done = 1'b1;
            r    = '{acc_q, ST_DIV0};
          end else begin
            err_q   = ST_DIV0;
            phase_q = DISCARD;
          end
        end else begin
          case (op_q)
            OP_ADD: acc_q = acc_q + opnd_q;
            OP_SUB: acc_q = acc_q - opnd_q;
            OP_MUL: acc_q = acc_q * opnd_q;
            default: begin
              quot  = int'($signed(acc_q)) / int'($signed(opnd_q));
              acc_q = 16'(quot);
            end
          endcase
          close_number(c, done, r);
        end
      end
      DISCARD: begin
        if (c == CH_NUL) begin
          done = 1'b1;
          r    = '{(err_q == ST_NO_LEAD) ? 16'sd0 : $signed(acc_q), err_q};
        end
      end
      default: begin
        if (is_digit) begin
          acc_q   = digit;
          phase_q = IN_LEAD;
        end else if (c == CH_NUL) begin
          done = 1'b1;
          r    = '{16'sd0, ST_NO_LEAD};
        end else begin
          err_q   = ST_NO_LEAD;
          phase_q = DISCARD;
        end
      end
    endcase
    if (done) clear_line();
  endtask

  // Valid stays high after a beat; it drops when the next character has a gap
  // or when the sender waits for results.
  task automatic send_char(input logic [7:0] c, input bit typed,
                           input logic signed [15:0] tv, input status_e ts);
    int           gap;
    bit           done;
    line_result_t r;
    gap = steady_line ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= c;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    chars_sent++;
    eval_char(c, done, r);
    if (done) result_q.push_back(typed ? line_result_t'{tv, ts} : r);
  endtask

  task automatic push_number();
    int len;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
    repeat (len) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic build_random_line();
    logic [7:0] ops [4];
    int         pairs;
    int         sel;
    ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    line_q.delete();
    if ($urandom_range(0, 99) < 82) begin
      push_number();
      pairs = $urandom_range(0, 4);
      repeat (pairs) begin
        sel = $urandom_range(0, 3);
        line_q.push_back(ops[sel]);
        if (ops[sel] == CH_SLASH && $urandom_range(0, 5) == 0) line_q.push_back(CH_ZERO);
        else push_number();
      end
      if ($urandom_range(0, 19) == 0) line_q.push_back(ops[$urandom_range(0, 3)]);
      if ($urandom_range(0, 9) == 0)
        line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(1, 255));
    end else begin
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 1) == 0) line_q.push_back(8'($urandom_range(1, 255)));
        else line_q.push_back(ops[$urandom_range(0, 3)]);
      end
    end
    line_q.push_back(CH_NUL);
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: per beat a random stall, with occasional bursts that never stall.
  initial begin : receiver
    int stall;
    int burst_left;
    burst_left = 0;
    forever begin
      if (burst_left > 0) begin
        stall = 0;
        burst_left--;
      end else begin
        stall = $urandom_range(0, MAX_IDLE);
        if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(3, 12);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  always @(posedge clk_i) begin
    line_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        status_seen[status_o]++;
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: value %0d status %0d", value_o, status_o);
        end else begin
          want = result_q.pop_front();
          if (value_o !== want.value || status_o !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected value %0d status %s, got value %0d status %0d",
                       results_seen, want.value, want.status.name(), value_o, status_o);
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no beat for %0d cycles, %0d results pending",
                   idle_cycles, result_q.size());
          $display("ascii_expression_evaluator_tb: FAIL");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int random_chars;
    clear_line();
    steady_line = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (line_table[i]) begin
      steady_line = (i % 3 == 0);
      for (int j = 0; j < line_table[i].txt.len(); j++)
        send_char(line_table[i].txt[j], 1'b0, 16'sd0, ST_OK);
      send_char(CH_NUL, line_table[i].typed, line_table[i].value, line_table[i].status);
      lines_sent++;
    end
    wait_all_results();

    random_chars = 0;
    while (random_chars < RANDOM_CHARS) begin
      build_random_line();
      steady_line = ($urandom_range(0, 3) == 0);
      foreach (line_q[k]) send_char(line_q[k], 1'b0, 16'sd0, ST_OK);
      random_chars += line_q.size();
      lines_sent++;
      if (lines_sent % 8 == 0) wait_all_results();
    end
    in_valid_i <= 1'b0;

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d characters in %0d lines and checked %0d results.",
             chars_sent, lines_sent, results_seen);
    $display("Status mix: ok %0d, no leading number %0d, bad %0d, divide by zero %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("ascii_expression_evaluator_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, result_q.size());
      $display("ascii_expression_evaluator_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
